[design/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside of reset
`define GPLE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define GPLE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/gple_pkg.sv]
// shared widths, codes, constants and the table entry type
// no dependencies; used by every module of the emission block
`timescale 1ns / 1ps

package gple_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;

  localparam int TIME_W     = 32;
  localparam int FLOW_W     = 32;
  localparam int AREA_W     = 24;
  localparam int COUNT_W    = 5;
  localparam int INDEX_W    = 4;
  localparam int OUT_W      = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // emission window length in seconds
  localparam logic [TIME_W-1:0] WINDOW_SECONDS = 32'd126000;

  // floor(0.000165 * 2^48)
  localparam int K_W = 36;
  localparam logic [K_W-1:0] SCALE_K = 36'd46443371157;

  localparam int MUL_A_W     = 64;
  localparam int MUL_B_W     = K_W;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int SCALE_SHIFT = 16;
  localparam int SCALED_W    = PROD_W - SCALE_SHIFT;

  localparam int DIV_DVD_W = 64;
  localparam int DIV_DVS_W = 32;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_AREA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAKPOINTS  = 2'd2;

  localparam logic [TIME_W-1:0]  ARRIVAL_RESET     = 32'd5600;
  localparam logic [AREA_W-1:0]  AREA_RESET        = 24'd0;
  localparam logic [COUNT_W-1:0] BREAKPOINTS_RESET = 5'd2;

  typedef struct packed {
    logic [TIME_W-1:0] bp_time;
    logic [FLOW_W-1:0] bp_flow;
  } entry_t;

endpackage

[design/gple_table.sv]
// breakpoint table: one write port, one registered read port
// depends on gple_pkg for the entry type
`timescale 1ns / 1ps

module gple_table #(
  parameter int unsigned DEPTH = gple_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  gple_pkg::entry_t         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output gple_pkg::entry_t         rd_data
);

  gple_pkg::entry_t mem_r [DEPTH];
  gple_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/gple_mul.sv]
// shift-add multiplier, one multiplier bit per cycle, lsb first
// depends on gple_pkg for operand widths
`timescale 1ns / 1ps

module gple_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gple_pkg::MUL_A_W-1:0]  a,
  input  logic [gple_pkg::MUL_B_W-1:0]  b,
  output logic                          done,
  output logic [gple_pkg::PROD_W-1:0]   prod
);

  localparam int A_W   = gple_pkg::MUL_A_W;
  localparam int B_W   = gple_pkg::MUL_B_W;
  localparam int P_W   = gple_pkg::PROD_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_r;
  logic [P_W-1:0]   p_r, p_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [A_W:0]     sum;

  // upper half accumulates, multiplier bits shift out of the lower half
  assign sum   = {1'b0, p_r[P_W-1:B_W]} + (p_r[0] ? {1'b0, a_r} : '0);
  assign p_nxt = {sum, p_r[B_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(B_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= P_W'(b);
    end else if (cnt_r != '0) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

[design/gple_div.sv]
// restoring divider, one quotient bit per cycle, msb first
// depends on gple_pkg for operand widths; remainder in must be below divisor
`timescale 1ns / 1ps

module gple_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [gple_pkg::DIV_DVD_W-1:0] dividend,
  input  logic [gple_pkg::DIV_DVS_W-1:0] divisor,
  input  logic [gple_pkg::DIV_DVS_W-1:0] rem_init,
  output logic                           done,
  output logic [gple_pkg::DIV_DVD_W-1:0] quotient
);

  localparam int DVD_W = gple_pkg::DIV_DVD_W;
  localparam int DVS_W = gple_pkg::DIV_DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // dividend bits leave at the top while quotient bits enter at the bottom
  assign trial   = {rem_r, q_r[DVD_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign fits    = (trial >= {1'b0, dvs_r});
  assign rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  assign q_nxt   = {q_r[DVD_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= rem_init;
      q_r   <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[design/gated_piecewise_linear_emission.sv]
// load: written into the table at its transfer, no result, next item in the next cycle
// evaluate: gated or out-of-range items end at the range check; others search the table,
//   then multiply and divide for the segment and for scaling and area; equal times skip
//   the first pair, a negative flow ends at the first divide, saturation skips the second
// one evaluation at a time; the result strobe lasts one cycle and cannot be stalled
// synchronous active-low reset restores state and settings; table contents stay as written
`timescale 1ns / 1ps

module gated_piecewise_linear_emission #(
  parameter int unsigned TABLE_DEPTH = gple_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [gple_pkg::INDEX_W-1:0]      in_entry_index,
  input  logic [gple_pkg::TIME_W-1:0]       in_entry_time,
  input  logic [gple_pkg::FLOW_W-1:0]       in_entry_flow,
  input  logic [gple_pkg::TIME_W-1:0]       in_begin_time,
  input  logic [gple_pkg::TIME_W-1:0]       in_activation_time,
  output logic                              out_valid,
  output logic [gple_pkg::OUT_W-1:0]        out_flux_per_area,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gple_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gple_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_RANGE  = 10'b00_0000_0010,
    S_FIRST  = 10'b00_0000_0100,
    S_SEARCH = 10'b00_0000_1000,
    S_CALC   = 10'b00_0001_0000,
    S_MUL1   = 10'b00_0010_0000,
    S_DIV1   = 10'b00_0100_0000,
    S_SCALE  = 10'b00_1000_0000,
    S_MUL2   = 10'b01_0000_0000,
    S_DIV2   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   done_flag_r, done_flag_nxt;

  logic [gple_pkg::TIME_W-1:0]  arrival_r;
  logic [gple_pkg::AREA_W-1:0]  area_r;
  logic [gple_pkg::COUNT_W-1:0] bpu_r;

  logic [gple_pkg::TIME_W-1:0] t_r, t_nxt;
  logic                        zero_r, zero_nxt;
  logic [IDX_W-1:0]            j_r, j_nxt;
  gple_pkg::entry_t            prev_r, prev_nxt;
  gple_pkg::entry_t            cur_r, cur_nxt;
  logic                        neg_r, neg_nxt;
  logic [63:0]                 flux_r, flux_nxt;
  logic [gple_pkg::OUT_W-1:0]  res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic             accept;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  gple_pkg::entry_t wr_data;
  logic [IDX_W-1:0] rd_addr;
  gple_pkg::entry_t rd_data;
  logic [IDX_W-1:0] last_idx;

  logic [gple_pkg::TIME_W:0] window_diff;
  logic                      closed;
  logic                      before_arrival;

  logic                        dt_neg, df_neg, den_neg;
  logic [gple_pkg::TIME_W-1:0] dt_mag, den_mag;
  logic [gple_pkg::FLOW_W-1:0] df_mag;
  logic [63:0]                 f0_ext;
  logic [64:0]                 sum_ext;

  logic                           mul_start, mul_done;
  logic [gple_pkg::MUL_A_W-1:0]   mul_a;
  logic [gple_pkg::MUL_B_W-1:0]   mul_b;
  logic [gple_pkg::PROD_W-1:0]    mul_prod;
  logic                           div_start, div_done;
  logic [gple_pkg::DIV_DVD_W-1:0] div_dividend, div_quot;
  logic [gple_pkg::DIV_DVS_W-1:0] div_divisor, div_rem_init;

  logic [gple_pkg::SCALED_W-1:0] scaled;
  logic [gple_pkg::AREA_W:0]     divisor_d;
  logic                          sat;

  assign busy      = (state_r != S_IDLE) || done_flag_r;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r <= gple_pkg::ARRIVAL_RESET;
      area_r    <= gple_pkg::AREA_RESET;
      bpu_r     <= gple_pkg::BREAKPOINTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gple_pkg::CFG_ARRIVAL_TIME: arrival_r <= cfg_data;
        gple_pkg::CFG_ACTIVE_AREA:  area_r    <= cfg_data[gple_pkg::AREA_W-1:0];
        gple_pkg::CFG_BREAKPOINTS:  bpu_r     <= cfg_data[gple_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // last valid entry, count clamped to 2..depth
  always_comb begin
    priority if (bpu_r < 5'd2) begin
      last_idx = IDX_W'(1);
    end else if (32'(bpu_r) > 32'(TABLE_DEPTH)) begin
      last_idx = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(bpu_r - 5'd1);
    end
  end

  assign wr_en   = accept && (in_command == gple_pkg::CMD_LOAD)
                   && (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = IDX_W'(in_entry_index);
  assign wr_data = '{bp_time: in_entry_time, bp_flow: in_entry_flow};

  gple_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // gating checks at the transfer
  assign before_arrival = (in_begin_time < arrival_r);
  assign window_diff    = {1'b0, in_begin_time} - {1'b0, in_activation_time};
  assign closed         = !window_diff[gple_pkg::TIME_W]
                          && (window_diff[gple_pkg::TIME_W-1:0] >= gple_pkg::WINDOW_SECONDS);

  // segment terms as sign and magnitude
  assign dt_neg  = (t_r < prev_r.bp_time);
  assign dt_mag  = dt_neg ? (prev_r.bp_time - t_r) : (t_r - prev_r.bp_time);
  assign df_neg  = (cur_r.bp_flow < prev_r.bp_flow);
  assign df_mag  = df_neg ? (prev_r.bp_flow - cur_r.bp_flow) : (cur_r.bp_flow - prev_r.bp_flow);
  assign den_neg = (cur_r.bp_time < prev_r.bp_time);
  assign den_mag = den_neg ? (prev_r.bp_time - cur_r.bp_time) : (cur_r.bp_time - prev_r.bp_time);

  assign f0_ext  = 64'(prev_r.bp_flow);
  assign sum_ext = {1'b0, f0_ext} + {1'b0, div_quot};

  assign scaled    = mul_prod[gple_pkg::PROD_W-1:gple_pkg::SCALE_SHIFT];
  assign divisor_d = {1'b0, area_r} + 25'd1;
  // quotient reaches 2^56 exactly when the top bits reach the divisor
  assign sat       = (scaled[gple_pkg::SCALED_W-1:gple_pkg::OUT_W]
                      >= (gple_pkg::SCALED_W - gple_pkg::OUT_W)'(divisor_d));

  assign mul_a = (state_r == S_SCALE) ? flux_r : gple_pkg::MUL_A_W'(dt_mag);
  assign mul_b = (state_r == S_SCALE) ? gple_pkg::SCALE_K : gple_pkg::MUL_B_W'(df_mag);

  assign div_dividend = (state_r == S_MUL2) ? scaled[gple_pkg::DIV_DVD_W-1:0]
                                            : mul_prod[gple_pkg::DIV_DVD_W-1:0];
  assign div_divisor  = (state_r == S_MUL2) ? gple_pkg::DIV_DVS_W'(divisor_d) : den_mag;
  assign div_rem_init = (state_r == S_MUL2)
                        ? gple_pkg::DIV_DVS_W'(scaled[gple_pkg::SCALED_W-1:gple_pkg::DIV_DVD_W])
                        : '0;

  gple_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  gple_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rem_init (div_rem_init),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    done_flag_nxt = 1'b0;
    t_nxt         = t_r;
    zero_nxt      = zero_r;
    j_nxt         = j_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    neg_nxt       = neg_r;
    flux_nxt      = flux_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    rd_addr       = '0;
    unique case (state_r)
      S_IDLE: begin
        // keep the last entry on the read port for the range check
        rd_addr = last_idx;
        if (done_flag_r) begin
          out_valid_nxt = 1'b1;
        end else if (accept && (in_command == gple_pkg::CMD_EVAL)) begin
          t_nxt     = in_begin_time - arrival_r;
          zero_nxt  = before_arrival || closed;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        if (zero_r || (t_r > rd_data.bp_time)) begin
          res_nxt       = '0;
          done_flag_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        prev_nxt  = rd_data;
        rd_addr   = IDX_W'(1);
        j_nxt     = IDX_W'(1);
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if ((rd_data.bp_time < t_r) && (j_r != last_idx)) begin
          prev_nxt = rd_data;
          j_nxt    = j_r + IDX_W'(1);
          rd_addr  = j_r + IDX_W'(1);
        end else begin
          cur_nxt   = rd_data;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (cur_r.bp_time == prev_r.bp_time) begin
          flux_nxt  = f0_ext;
          state_nxt = S_SCALE;
        end else begin
          mul_start = 1'b1;
          neg_nxt   = dt_neg ^ df_neg ^ den_neg;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          if (neg_r && (div_quot != '0)) begin
            // a flow below zero gives a zero result
            if (div_quot > f0_ext) begin
              res_nxt       = '0;
              done_flag_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              flux_nxt  = f0_ext - div_quot;
              state_nxt = S_SCALE;
            end
          end else begin
            flux_nxt  = sum_ext[64] ? '1 : sum_ext[63:0];
            state_nxt = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        mul_start = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        if (mul_done) begin
          if (sat) begin
            res_nxt       = gple_pkg::OUT_MAX;
            done_flag_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_done) begin
          res_nxt       = div_quot[gple_pkg::OUT_W-1:0];
          done_flag_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_flag_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_flag_r <= done_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    zero_r <= zero_nxt;
    j_r    <= j_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    neg_r  <= neg_nxt;
    flux_r <= flux_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_flux_per_area = res_r;

endmodule

[design/gple_checker.sv]
// port-level checks of the emission block, attached to the top level by bind
// depends on gple_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gple_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_command,
  input logic out_valid
);

  `GPLE_ASSERT(a_result_not_busy, clk, rst_n, out_valid |-> !busy, "result strobe while busy")
  `GPLE_ASSERT(a_eval_goes_busy, clk, rst_n, start && !busy && (in_command == gple_pkg::CMD_EVAL) |=> busy, "evaluate transfer did not start work")
  `GPLE_ASSERT(a_load_stays_idle, clk, rst_n, start && !busy && (in_command == gple_pkg::CMD_LOAD) |=> !busy && !out_valid, "load transfer caused work or a result")
  `GPLE_ASSERT(a_finish_gives_result, clk, rst_n, $fell(busy) && $past(rst_n) |-> out_valid, "evaluation ended without a result")
  `GPLE_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !busy && !out_valid, "reset left work or a result pending")

endmodule

bind gated_piecewise_linear_emission gple_checker u_gple_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid)
);

[verif/gated_piecewise_linear_emission_tb.sv]
// self-checking testbench for gated_piecewise_linear_emission: table loads, gated
// interpolation, scaling and area division checked against an in-bench predictor
// depends on gple_pkg and the gated_piecewise_linear_emission module
`timescale 1ns / 1ps

module gated_piecewise_linear_emission_tb;
  import gple_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 240;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 35;

  // predicts flux per area from its own copy of the registers and the table
  class flux_scoreboard;
    logic [TIME_W-1:0]  arrival;
    logic [AREA_W-1:0]  area;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  tbl_time [TABLE_DEPTH_DEF];
    logic [FLOW_W-1:0]  tbl_flow [TABLE_DEPTH_DEF];
    logic [OUT_W-1:0]   flux_due [$];
    int errors, loads, evals, zeros, writes;

    function new();
      arrival = ARRIVAL_RESET;
      area = AREA_RESET;
      count = BREAKPOINTS_RESET;
      foreach (tbl_time[i]) begin
        tbl_time[i] = '0;
        tbl_flow[i] = '0;
      end
      errors = 0;
      loads = 0;
      evals = 0;
      zeros = 0;
      writes = 0;
    endfunction

    function int unsigned used_entries();
      if (count < 2) return 2;
      if (count > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
      return count;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ARRIVAL_TIME: arrival = data[TIME_W-1:0];
        CFG_ACTIVE_AREA:  area = data[AREA_W-1:0];
        CFG_BREAKPOINTS:  count = data[COUNT_W-1:0];
        default: ;
      endcase
      writes++;
    endfunction

    function logic [OUT_W-1:0] flux_at(logic [TIME_W-1:0] bt, logic [TIME_W-1:0] at);
      int unsigned n, h;
      logic [TIME_W-1:0] t, t0, t1, dt, den;
      logic [FLOW_W-1:0] f0, f1, df;
      logic [63:0] q;
      logic [64:0] flow;
      logic [127:0] scaled;
      longint win;
      n = used_entries();
      if (bt < arrival) return '0;
      t = bt - arrival;
      if (t > tbl_time[n-1]) return '0;
      win = longint'(bt) - longint'(at);
      if (win >= longint'(WINDOW_SECONDS)) return '0;
      h = 0;
      while (h + 1 < n && tbl_time[h+1] < t) h++;
      t0 = tbl_time[h];
      t1 = tbl_time[h+1];
      f0 = tbl_flow[h];
      f1 = tbl_flow[h+1];
      if (t1 == t0) begin
        flow = 65'(f0);
      end else begin
        dt = (t < t0) ? t0 - t : t - t0;
        df = (f1 < f0) ? f0 - f1 : f1 - f0;
        den = (t1 < t0) ? t0 - t1 : t1 - t0;
        q = (64'(dt) * 64'(df)) / 64'(den);
        if (((t < t0) ^ (f1 < f0) ^ (t1 < t0)) && q != 0) begin
          // extrapolating below zero flow kills the result
          if (q > 64'(f0)) return '0;
          flow = 65'(f0) - 65'(q);
        end else begin
          flow = 65'(f0) + 65'(q);
          if (flow[64]) flow = {1'b0, {64{1'b1}}};
        end
      end
      scaled = (128'(flow) * 128'(SCALE_K)) >> SCALE_SHIFT;
      scaled = scaled / (128'(area) + 128'd1);
      if (scaled > 128'(OUT_MAX)) return OUT_MAX;
      return scaled[OUT_W-1:0];
    endfunction

    function void note_item(logic cmd, logic [INDEX_W-1:0] idx, logic [TIME_W-1:0] et,
                            logic [FLOW_W-1:0] ef, logic [TIME_W-1:0] bt,
                            logic [TIME_W-1:0] at);
      logic [OUT_W-1:0] flux;
      if (cmd == CMD_LOAD) begin
        if (idx < TABLE_DEPTH_DEF) begin
          tbl_time[idx] = et;
          tbl_flow[idx] = ef;
        end
        loads++;
      end else begin
        flux = flux_at(bt, at);
        if (flux == '0) zeros++;
        flux_due.push_back(flux);
        evals++;
      end
    endfunction

    function void check_flux(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (flux_due.size() == 0) begin
        $error("unexpected result: flux_per_area actual %h", got);
        errors++;
        return;
      end
      want = flux_due.pop_front();
      if (got !== want) begin
        $error("flux_per_area mismatch: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return flux_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_LOAD;
  logic [INDEX_W-1:0] in_entry_index = '0;
  logic [TIME_W-1:0] in_entry_time = '0;
  logic [FLOW_W-1:0] in_entry_flow = '0;
  logic [TIME_W-1:0] in_begin_time = '0;
  logic [TIME_W-1:0] in_activation_time = '0;
  logic out_valid;
  logic [OUT_W-1:0] out_flux_per_area;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ARRIVAL_TIME;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  flux_scoreboard sb;
  bit quiet = 1'b0;
  int stall_cycles = 0;

  gated_piecewise_linear_emission u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_entry_index     (in_entry_index),
    .in_entry_time      (in_entry_time),
    .in_entry_flow      (in_entry_flow),
    .in_begin_time      (in_begin_time),
    .in_activation_time (in_activation_time),
    .out_valid          (out_valid),
    .out_flux_per_area  (out_flux_per_area),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_flux(out_flux_per_area);
  end

  // ends the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                           input logic [TIME_W-1:0] et, input logic [FLOW_W-1:0] ef,
                           input logic [TIME_W-1:0] bt, input logic [TIME_W-1:0] at);
    if (!quiet) begin
      while ($urandom_range(99) < 30) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start = 1'b1;
    in_command = cmd;
    in_entry_index = idx;
    in_entry_time = et;
    in_entry_flow = ef;
    in_begin_time = bt;
    in_activation_time = at;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(cmd, idx, et, ef, bt, at);
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] slot, input logic [TIME_W-1:0] et,
                            input logic [FLOW_W-1:0] ef);
    send_item(CMD_LOAD, slot, et, ef, $urandom, $urandom);
  endtask

  task automatic eval_at(input logic [TIME_W-1:0] bt, input logic [TIME_W-1:0] at);
    send_item(CMD_EVAL, INDEX_W'($urandom), $urandom, $urandom, bt, at);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    start = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold off until every evaluation has come back, then let the block settle
  task automatic wait_idle(input int tail);
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  initial begin
    int unsigned n, lo, hi, step, r;
    logic [TIME_W-1:0] t, bt, at, base, arr_v;
    logic [FLOW_W-1:0] f;
    logic [AREA_W-1:0] area_v;
    logic [COUNT_W-1:0] cnt_v;
    logic [INDEX_W-1:0] slot;
    bit sorted;

    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill the whole table first so no unwritten entry is ever read
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
      t = (i == TABLE_DEPTH_DEF - 1) ? '1 : TIME_W'(i * 1000);
      f = (i == 14) ? '1 : (i == 13) ? '0 : $urandom;
      load_entry(INDEX_W'(i), t, f);
    end

    // reset settings: arrival 5600, two entries in use
    load_entry(0, 1000, 32'h0001_0000);
    load_entry(1, 2000, 32'h0003_0000);
    eval_at(5599, 0);
    eval_at(5600 + 1500, 5600);
    eval_at(5600 + 2000, 5600);
    eval_at(5600 + 2001, 5600);
    eval_at(5600 + 500, 5600);
    eval_at(5600 + 1500, 5600 + 1500 - 126000);
    eval_at(5600 + 1200, 5600 + 1200 - 125999);
    eval_at(5600 + 1700, '1);

    // backward extrapolation of a rising segment goes below zero
    load_entry(0, 5000, 32'h0001_0000);
    load_entry(1, 6000, 32'h0010_0000);
    eval_at(5600, 5600);

    // segment with equal times keeps the first flow
    load_entry(0, 3000, 32'h0002_0000);
    load_entry(1, 3000, 32'h0005_0000);
    eval_at(5600 + 3000, 5600);
    eval_at(5600 + 100, 5600);

    // descending times, one second apart: the first evaluation gets the largest flow and saturates
    wait_idle(SETTLE_CYCLES);
    write_reg(CFG_ARRIVAL_TIME, '0);
    load_entry(0, '1, '0);
    load_entry(1, 32'hFFFF_FFFE, '1);
    eval_at('0, '0);
    eval_at(32'hFFFF_FFFE, '1);
    eval_at('1, '1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle(SETTLE_CYCLES);
      arr_v = $urandom_range(0, 1000000);
      area_v = AREA_W'($urandom_range(0, 15));
      cnt_v = COUNT_W'($urandom_range(2, 16));
      case (ph)
        0: begin
          arr_v = '0;
          area_v = '0;
          cnt_v = 16;
        end
        1: begin
          area_v = '1;
          cnt_v = 16;
        end
        2: begin
          arr_v = '1;
          area_v = '0;
          cnt_v = 2;
        end
        3: begin
          arr_v = $urandom;
          area_v = AREA_W'($urandom);
          cnt_v = 31;
        end
        4: cnt_v = 0;
        5: cnt_v = 1;
        6: cnt_v = 17;
        default: if ($urandom_range(1)) area_v = AREA_W'($urandom);
      endcase
      write_reg(CFG_ARRIVAL_TIME, arr_v);
      write_reg(CFG_ACTIVE_AREA, {8'($urandom), area_v});
      write_reg(CFG_BREAKPOINTS, {27'($urandom), cnt_v});
      if (ph == 4) write_reg(CFG_UNMAPPED, $urandom);
      quiet = (ph == 7);

      // mostly ascending tables, some scrambled
      sorted = ($urandom_range(9) < 7);
      step = $urandom_range(1) ? 20000 : 200000000;
      base = $urandom_range(0, 5000);
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
        t = sorted ? base : ($urandom_range(1) ? $urandom : $urandom_range(0, 100000));
        f = $urandom_range(1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
        load_entry(INDEX_W'(i), t, f);
        base = base + $urandom_range(0, step);
      end

      n = sb.used_entries();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 3) wait_idle(0);
        lo = sb.tbl_time[0];
        hi = sb.tbl_time[n-1];
        if ($urandom_range(99) < 15) begin
          slot = INDEX_W'($urandom);
          t = $urandom_range(1) ? sb.tbl_time[slot] + $urandom_range(0, 50) : $urandom;
          load_entry(slot, t, $urandom);
        end else begin
          r = $urandom_range(99);
          if (r < 70) t = $urandom_range(lo, hi);
          else if (r < 78) t = sb.tbl_time[$urandom_range(0, n - 1)];
          else if (r < 86) t = $urandom_range(0, lo);
          else t = hi + $urandom_range(1, 1000);
          bt = (r < 94) ? sb.arrival + t : $urandom;
          r = $urandom_range(99);
          if (r < 75) at = bt - $urandom_range(0, 125999);
          else if (r < 85) at = bt - 126000 - $urandom_range(0, 1000);
          else if (r < 92) at = bt + $urandom_range(1, 1000000);
          else at = $urandom;
          eval_at(bt, at);
        end
      end
    end

    wait_idle(TAIL_CYCLES);
    if (sb.pending() != 0) begin
      $error("%0d flux_per_area results never arrived", sb.pending());
      sb.errors++;
    end
    $display("covered %0d table loads and %0d evaluations (%0d expected zero)",
             sb.loads, sb.evals, sb.zeros);
    $display("over %0d register writes, table sizes clamped from 0 to 31", sb.writes);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/gple_pkg.sv
design/gple_table.sv
design/gple_mul.sv
design/gple_div.sv
design/gated_piecewise_linear_emission.sv
design/gple_checker.sv
verif/gated_piecewise_linear_emission_tb.sv
